### rtl/asa_pkg.sv
`timescale 1ns / 1ps

package asa_pkg;

    localparam int MAX_ALLOCS_DEF = 64;

    localparam logic [31:0] REGION_START_RST = 32'd0;
    localparam logic [31:0] REGION_SIZE_RST  = 32'd65536;
    localparam logic [6:0]  HEADER_BYTES_RST = 7'd8;

    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_SIZE  = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] request_size;
        logic [7:0]  alignment;
        logic [31:0] free_address;
    } t_asa_in;

    typedef struct packed {
        logic [31:0] block_address;
        logic [2:0]  status;
        logic [31:0] used_bytes;
        logic [6:0]  live_count;
    } t_asa_out;

    typedef struct packed {
        logic [7:0]  adj;
        logic [31:0] addr;
    } t_stack_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctrl;

endpackage

### rtl/asa_stack.sv
`timescale 1ns / 1ps

module asa_stack
    import asa_pkg::*;
#(
    parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
    input  logic                                 i_clk,
    input  t_stack_ctrl                          i_ctrl,
    input  t_stack_entry                         i_entry,
    input  logic [$clog2(MAX_ALLOCS + 1) - 1:0]  i_count,
    input  logic [$clog2(MAX_ALLOCS + 1) - 1:0]  i_next_count,
    output t_stack_entry                         o_top
);

    localparam int CW = $clog2(MAX_ALLOCS + 1);
    localparam int IW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;

    // top entry lives in r_top, the one below it is prefetched into r_below,
    // the rest sit in the memory
    t_stack_entry r_mem [MAX_ALLOCS];
    t_stack_entry r_top;
    t_stack_entry r_below;

    logic [CW-1:0] w_wr_full;
    logic [CW-1:0] w_rd_full;

    assign w_wr_full = i_count - CW'(1);
    assign w_rd_full = i_next_count - CW'(2);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && (i_count != '0)) begin
            r_mem[w_wr_full[IW-1:0]] <= r_top;
        end
        if (i_ctrl.push) begin
            r_below <= r_top;
        end else begin
            r_below <= r_mem[w_rd_full[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_top <= i_entry;
        end else if (i_ctrl.pop) begin
            r_top <= r_below;
        end
    end

    assign o_top = r_top;

endmodule

### rtl/aligned_stack_allocator.sv
`timescale 1ns / 1ps
// LIFO region allocator with aligned blocks and a per-block header gap.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is an
// allocate (size, alignment) or a free of the most recent live block.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// transaction per input transaction, in order: granted address, status,
// bytes in use and number of live blocks after the request.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// index 0 region start, 1 region size, 2 header bytes; always ready. Users
// write it only while no request is in flight; the block does not enforce it.
// A request is registered in the input register at acceptance and its result
// is registered in the output register when it fires. Throughput is one
// request per cycle while the receiver does not stall. A request touches
// only the top offset, the byte and block counters and the stack top.
// Reset (synchronous, active low) empties the allocator and restores the
// config defaults (start 0, size 65536, header 8).
// When the receiver stalls, the result is held and one more request can
// still be taken into the input register; then o_in_ready drops.
module aligned_stack_allocator
    import asa_pkg::*;
#(
    parameter int MAX_ALLOCS = MAX_ALLOCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_asa_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_asa_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_ALLOCS + 1);

    function automatic logic [7:0] pow2_floor(input logic [7:0] a);
        logic [7:0] p;
        if (a[7])      p = 8'd128;
        else if (a[6]) p = 8'd64;
        else if (a[5]) p = 8'd32;
        else if (a[4]) p = 8'd16;
        else if (a[3]) p = 8'd8;
        else if (a[2]) p = 8'd4;
        else if (a[1]) p = 8'd2;
        else           p = 8'd1;
        return p;
    endfunction

    function automatic logic [7:0] forward_adjust(input logic [7:0] addr,
                                                  input logic [7:0] align,
                                                  input logic [6:0] hdr);
        logic [7:0] mask;
        logic [7:0] mis;
        logic [8:0] adj;
        logic [8:0] need;
        mask = align - 8'd1;
        mis  = addr & mask;
        adj  = (mis != 8'd0) ? ({1'b0, align} - {1'b0, mis}) : 9'd0;
        need = {2'b00, hdr} - adj;
        if (adj < {2'b00, hdr}) begin
            adj = adj + (need & ~{1'b0, mask});
            if ((need & {1'b0, mask}) != 9'd0) begin
                adj = adj + {1'b0, align};
            end
        end
        return adj[7:0];
    endfunction

    logic [31:0]   r_start;
    logic [31:0]   r_size;
    logic [6:0]    r_hdr;
    logic [31:0]   r_top_off;
    logic [31:0]   r_used;
    logic [CW-1:0] r_count;
    logic          r_in_valid;
    t_asa_in       r_in;
    logic          r_out_valid;
    t_asa_out      r_out;

    logic [31:0]   n_top_off;
    logic [31:0]   n_used;
    logic [CW-1:0] n_count;
    t_asa_out      n_out;

    logic          w_fire;
    logic [31:0]   w_cur;
    logic [7:0]    w_align;
    logic [7:0]    w_adj;
    logic [33:0]   w_need;
    logic          w_no_space;
    logic          w_full;
    logic          w_bad_free;
    t_stack_ctrl   w_ctrl;
    t_stack_entry  w_push_entry;
    t_stack_entry  w_top;
    logic [31:0]   w_count32;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= REGION_START_RST;
            r_size  <= REGION_SIZE_RST;
            r_hdr   <= HEADER_BYTES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REGION_START: r_start <= i_cfg_data;
                CFG_REGION_SIZE:  r_size  <= i_cfg_data;
                CFG_HEADER_BYTES: r_hdr   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    assign w_cur      = r_start + r_top_off;
    assign w_align    = pow2_floor(r_in.alignment);
    assign w_adj      = forward_adjust(w_cur[7:0], w_align, r_hdr);
    assign w_need     = {2'b00, r_used} + {26'd0, w_adj} + {2'b00, r_in.request_size};
    assign w_no_space = w_need > {2'b00, r_size};
    assign w_full     = r_count >= CW'(MAX_ALLOCS);
    assign w_bad_free = (r_count == '0) || (w_top.addr != r_in.free_address);

    assign w_push_entry.adj  = w_adj;
    assign w_push_entry.addr = w_cur + {24'd0, w_adj};

    always_comb begin
        w_ctrl    = '0;
        n_top_off = r_top_off;
        n_used    = r_used;
        n_count   = r_count;
        n_out.block_address = 32'd0;
        n_out.status        = ST_OK;
        if (r_in.kind == KIND_ALLOC) begin
            if (r_in.request_size == 32'd0) begin
                n_out.status = ST_ZERO_SIZE;
            end else if (w_no_space) begin
                n_out.status = ST_NO_SPACE;
            end else if (w_full) begin
                n_out.status = ST_FULL;
            end else begin
                w_ctrl.push = w_fire;
                n_out.block_address = w_push_entry.addr;
                n_top_off = r_top_off + {24'd0, w_adj} + r_in.request_size;
                n_used    = w_need[31:0];
                n_count   = r_count + CW'(1);
            end
        end else begin
            if (w_bad_free) begin
                n_out.status = ST_BAD_FREE;
            end else begin
                w_ctrl.pop = w_fire;
                n_used    = r_used - ((w_cur - r_in.free_address) + {24'd0, w_top.adj});
                n_top_off = (r_in.free_address - r_start) - {24'd0, w_top.adj};
                n_count   = r_count - CW'(1);
            end
        end
        n_out.used_bytes = n_used;
        w_count32        = 32'(n_count);
        n_out.live_count = w_count32[6:0];
    end

    asa_stack #(
        .MAX_ALLOCS(MAX_ALLOCS)
    ) u_stack (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_entry      (w_push_entry),
        .i_count      (r_count),
        .i_next_count (w_fire ? n_count : r_count),
        .o_top        (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_off   <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_top_off <= n_top_off;
                r_used    <= n_used;
                r_count   <= n_count;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ALLOCS))
        else $error("live count above stack depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> r_count == $past(r_count) + CW'(1))
        else $error("allocate did not bump live count");

    a_fail_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (n_out.status != ST_OK) |=> $stable(r_used) && $stable(r_top_off))
        else $error("failed transaction changed allocator state");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.push && w_ctrl.pop))
        else $error("push and pop in one cycle");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_BAD_FREE))
        else $error("status code out of range");

endmodule
